// ----- design/cra_pkg.sv -----
// Package with the types, codes and constants of the contiguous region allocator.
package cra_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int IDX_BITS = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam logic [16:0] POOL_MAX = 17'h10000;

   // Operation codes carried in req_type.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_COMPACT = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   // Fit policies.
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_BAD = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOFIT = 3'd1;
   localparam logic [2:0] ST_POLICY = 3'd2;
   localparam logic [2:0] ST_OWNER = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_BAD = 3'd5;

   typedef struct packed {
      logic [15:0] start_addr;
      logic [15:0] end_addr;
      logic [7:0]  owner;
      logic        used;
   } entry_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  owner_id;
      logic [16:0] req_size;
      logic [1:0]  fit_policy;
      logic [6:0]  entry_index;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  region_index;
      logic [15:0] region_start;
      logic [15:0] region_end;
      logic [7:0]  region_owner;
      logic        region_used;
      logic [7:0]  region_total;
      logic [16:0] free_words;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_REL_NEXT,
      S_SHIFT_UP,
      S_SPLIT_LO,
      S_SPLIT_HI,
      S_SHIFT_DN,
      S_READ_WAIT,
      S_RESP
   } fsm_state_type;

endpackage

// ----- design/cra_table.sv -----
// Region table memory: one write port and one registered read port.
module cra_table (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [cra_pkg::IDX_BITS-1:0]        wr_addr,
   input  cra_pkg::entry_type                  wr_data,
   input  logic [cra_pkg::IDX_BITS-1:0]        rd_addr,
   output cra_pkg::entry_type                  rd_data
);

   cra_pkg::entry_type mem [cra_pkg::MAX_ENTRIES];
   cra_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data follows the address in the next cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/contiguous_region_allocator.sv -----
// Contiguous region allocator: table of regions in memory, walked by a sequencer.
//
// The region table sits in a memory with one write port and one registered read
// port, and a request that walks it reads one entry a cycle. A read returns a
// single entry, and an alloc request with a bad policy or a zero size is answered
// without a walk. An alloc scans the whole table; it then answers when nothing
// fits or the table is full, marks the chosen entry used for an exact fit, and
// for a split moves the entries above the chosen one up, marks it used and
// writes the free remainder above it. A release scans up to the owner's region,
// or the whole table when the owner has none; it writes the merged region and,
// if a free neighbor was merged, moves the entries above it down. A compact
// scans the whole table and packs the used regions at the bottom. Requests
// are taken one at a time; a result waits in an output register, so the next
// request beat is taken while it is still unread, and a stalled result holds the
// sequencer once the next result is ready. After reset and after every pool_size
// write the block writes the single free region that covers the pool before it
// takes a request.
module contiguous_region_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cra_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cra_pkg::rsp_beat_type rsp_beat,
   input  logic                  csr_we,
   input  logic [16:0]           csr_wdata
);

   localparam int IB = cra_pkg::IDX_BITS;
   localparam int CB = cra_pkg::CNT_BITS;
   localparam logic [CB-1:0] MAX_CNT = CB'(cra_pkg::MAX_ENTRIES);

   cra_pkg::fsm_state_type state_ff, state_in;
   logic [16:0]           pool_ff, pool_in;
   logic [CB-1:0]         count_ff, count_in;
   logic [1:0]            op_ff, op_in;
   logic [7:0]            owner_ff, owner_in;
   logic [16:0]           size_ff, size_in;
   logic [1:0]            policy_ff, policy_in;
   logic [CB-1:0]         scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [CB-1:0]         pidx_ff, pidx_in;
   logic                  found_ff, found_in;
   logic [IB-1:0]         hit_ff, hit_in;
   cra_pkg::entry_type    hit_ent_ff, hit_ent_in;
   logic [16:0]           hit_len_ff, hit_len_in;
   cra_pkg::entry_type    prev_ent_ff, prev_ent_in;
   logic                  prev_free_ff, prev_free_in;
   logic [16:0]           ptr_ff, ptr_in;
   logic [CB-1:0]         kept_ff, kept_in;
   logic [1:0]            dist_ff, dist_in;
   cra_pkg::rsp_beat_type res_ff, res_in;
   cra_pkg::rsp_beat_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  mem_we;
   logic [IB-1:0]         mem_waddr;
   cra_pkg::entry_type    mem_wdata;
   logic [IB-1:0]         mem_raddr;
   cra_pkg::entry_type    rdata;

   logic [16:0]           d_len;
   logic                  scan_more;
   logic                  scan_done;
   logic                  rel_hit;
   logic                  next_free;
   logic                  alloc_split;
   logic                  up_more;
   logic                  dn_more;
   logic                  out_free;
   logic                  req_take;
   logic [16:0]           pool_clamp;
   logic [15:0]           pool_last;

   cra_table u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rdata)
   );

   // Shared conditions.
   assign d_len = {1'b0, rdata.end_addr} - {1'b0, rdata.start_addr} + 17'd1;
   assign scan_more = scan_ff < count_ff;
   assign scan_done = !pend_ff && !scan_more;
   assign rel_hit = (op_ff == cra_pkg::OP_RELEASE) && pend_ff && rdata.used &&
                    (rdata.owner == owner_ff);
   assign next_free = pend_ff && !rdata.used;
   assign alloc_split = hit_len_ff != size_ff;
   assign up_more = scan_ff > ({1'b0, hit_ff} + CB'(1));
   assign dn_more = (scan_ff + CB'(dist_ff)) < count_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != cra_pkg::S_IDLE) || csr_we;
   assign req_take = req_valid && !req_stall;
   assign pool_last = 16'(pool_ff - 17'd1);

   // Clamp a pool size write into the legal range.
   always_comb begin
      pool_clamp = csr_wdata;
      if (csr_wdata == 17'd0) begin
         pool_clamp = 17'd1;
      end else if (csr_wdata > cra_pkg::POOL_MAX) begin
         pool_clamp = cra_pkg::POOL_MAX;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cra_pkg::S_INIT: begin
            state_in = cra_pkg::S_IDLE;
         end
         cra_pkg::S_IDLE: begin
            if (req_take) begin
               case (req_beat.req_type)
                  cra_pkg::OP_ALLOC: begin
                     if (req_beat.fit_policy == cra_pkg::FIT_BAD ||
                         req_beat.req_size == 17'd0) begin
                        state_in = cra_pkg::S_RESP;
                     end else begin
                        state_in = cra_pkg::S_SCAN;
                     end
                  end
                  cra_pkg::OP_READ: state_in = cra_pkg::S_READ_WAIT;
                  default: state_in = cra_pkg::S_SCAN;
               endcase
            end
         end
         cra_pkg::S_SCAN: begin
            if (rel_hit) begin
               state_in = cra_pkg::S_REL_NEXT;
            end else if (scan_done) begin
               if (op_ff == cra_pkg::OP_ALLOC && found_ff) begin
                  if (!alloc_split) begin
                     state_in = cra_pkg::S_SPLIT_LO;
                  end else if (count_ff >= MAX_CNT) begin
                     state_in = cra_pkg::S_RESP;
                  end else begin
                     state_in = cra_pkg::S_SHIFT_UP;
                  end
               end else begin
                  state_in = cra_pkg::S_RESP;
               end
            end
         end
         cra_pkg::S_REL_NEXT: begin
            if (prev_free_ff || next_free) begin
               state_in = cra_pkg::S_SHIFT_DN;
            end else begin
               state_in = cra_pkg::S_RESP;
            end
         end
         cra_pkg::S_SHIFT_UP: begin
            if (!up_more && !pend_ff) begin
               state_in = cra_pkg::S_SPLIT_LO;
            end
         end
         cra_pkg::S_SPLIT_LO: begin
            state_in = alloc_split ? cra_pkg::S_SPLIT_HI : cra_pkg::S_RESP;
         end
         cra_pkg::S_SPLIT_HI: state_in = cra_pkg::S_RESP;
         cra_pkg::S_SHIFT_DN: begin
            if (!dn_more && !pend_ff) begin
               state_in = cra_pkg::S_RESP;
            end
         end
         cra_pkg::S_READ_WAIT: state_in = cra_pkg::S_RESP;
         cra_pkg::S_RESP: begin
            if (out_free) begin
               state_in = cra_pkg::S_IDLE;
            end
         end
         default: state_in = cra_pkg::S_INIT;
      endcase
      if (csr_we) begin
         state_in = cra_pkg::S_INIT;
      end
   end

   // Memory accesses and datapath for each state.
   always_comb begin
      pool_in = pool_ff;
      count_in = count_ff;
      op_in = op_ff;
      owner_in = owner_ff;
      size_in = size_ff;
      policy_in = policy_ff;
      scan_in = scan_ff;
      pend_in = 1'b0;
      pidx_in = pidx_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      hit_ent_in = hit_ent_ff;
      hit_len_in = hit_len_ff;
      prev_ent_in = prev_ent_ff;
      prev_free_in = prev_free_ff;
      ptr_in = ptr_ff;
      kept_in = kept_ff;
      dist_in = dist_ff;
      res_in = res_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = scan_ff[IB-1:0];

      case (state_ff)
         // Write the single free region that covers the pool.
         cra_pkg::S_INIT: begin
            mem_we = 1'b1;
            mem_wdata.end_addr = pool_last;
            count_in = CB'(1);
         end

         // Take a request beat and start its walk.
         cra_pkg::S_IDLE: begin
            mem_raddr = req_beat.entry_index;
            if (req_take) begin
               op_in = req_beat.req_type;
               owner_in = req_beat.owner_id;
               size_in = req_beat.req_size;
               policy_in = req_beat.fit_policy;
               scan_in = '0;
               found_in = 1'b0;
               ptr_in = '0;
               kept_in = '0;
               res_in = '0;
               res_in.region_total = count_ff;
               pidx_in = CB'(req_beat.entry_index);
               if (req_beat.req_type == cra_pkg::OP_ALLOC) begin
                  if (req_beat.fit_policy == cra_pkg::FIT_BAD) begin
                     res_in.status = cra_pkg::ST_POLICY;
                  end else if (req_beat.req_size == 17'd0) begin
                     res_in.status = cra_pkg::ST_BAD;
                  end
               end
            end
         end

         // Walk the table, one entry read per cycle.
         cra_pkg::S_SCAN: begin
            if (scan_more) begin
               pend_in = 1'b1;
               pidx_in = scan_ff;
               scan_in = scan_ff + CB'(1);
            end
            if (pend_ff) begin
               // Keep the entry below the released region for the merge.
               if (!rel_hit) begin
                  prev_ent_in = rdata;
               end
               case (op_ff)
                  cra_pkg::OP_ALLOC: begin
                     if (!rdata.used && d_len >= size_ff &&
                         (!found_ff ||
                          (policy_ff == cra_pkg::FIT_BEST && d_len < hit_len_ff) ||
                          (policy_ff == cra_pkg::FIT_WORST && d_len > hit_len_ff))) begin
                        found_in = 1'b1;
                        hit_in = pidx_ff[IB-1:0];
                        hit_ent_in = rdata;
                        hit_len_in = d_len;
                     end
                  end
                  cra_pkg::OP_RELEASE: begin
                     if (rel_hit) begin
                        hit_in = pidx_ff[IB-1:0];
                        hit_ent_in = rdata;
                        prev_free_in = (pidx_ff != '0) && !prev_ent_ff.used;
                     end
                  end
                  cra_pkg::OP_COMPACT: begin
                     if (rdata.used) begin
                        mem_we = 1'b1;
                        mem_waddr = kept_ff[IB-1:0];
                        mem_wdata.start_addr = ptr_ff[15:0];
                        mem_wdata.end_addr = 16'(ptr_ff + d_len - 17'd1);
                        mem_wdata.owner = rdata.owner;
                        mem_wdata.used = 1'b1;
                        ptr_in = ptr_ff + d_len;
                        kept_in = kept_ff + CB'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (scan_done) begin
               case (op_ff)
                  cra_pkg::OP_ALLOC: begin
                     if (!found_ff) begin
                        res_in.status = cra_pkg::ST_NOFIT;
                     end else if (alloc_split && count_ff >= MAX_CNT) begin
                        res_in.status = cra_pkg::ST_FULL;
                     end
                     scan_in = count_ff;
                  end
                  cra_pkg::OP_RELEASE: begin
                     res_in.status = cra_pkg::ST_OWNER;
                  end
                  default: begin
                     // Close the compaction with the free tail, if any.
                     res_in.status = cra_pkg::ST_OK;
                     count_in = kept_ff;
                     res_in.region_total = kept_ff;
                     if (ptr_ff < pool_ff && kept_ff < MAX_CNT) begin
                        mem_we = 1'b1;
                        mem_waddr = kept_ff[IB-1:0];
                        mem_wdata.start_addr = ptr_ff[15:0];
                        mem_wdata.end_addr = pool_last;
                        count_in = kept_ff + CB'(1);
                        res_in.region_index = kept_ff[IB-1:0];
                        res_in.region_start = ptr_ff[15:0];
                        res_in.region_end = pool_last;
                        res_in.region_total = kept_ff + CB'(1);
                        res_in.free_words = pool_ff - ptr_ff;
                     end
                  end
               endcase
            end
         end

         // Merge the released region with its free neighbors.
         cra_pkg::S_REL_NEXT: begin
            mem_we = 1'b1;
            mem_waddr = prev_free_ff ? hit_ff - IB'(1) : hit_ff;
            mem_wdata.start_addr = prev_free_ff ? prev_ent_ff.start_addr :
                                                  hit_ent_ff.start_addr;
            mem_wdata.end_addr = next_free ? rdata.end_addr : hit_ent_ff.end_addr;
            dist_in = {1'b0, prev_free_ff} + {1'b0, next_free};
            scan_in = {1'b0, mem_waddr} + CB'(1);
            res_in.status = cra_pkg::ST_OK;
            res_in.region_index = mem_waddr;
            res_in.region_start = mem_wdata.start_addr;
            res_in.region_end = mem_wdata.end_addr;
            res_in.region_owner = '0;
            res_in.region_used = 1'b0;
            res_in.region_total = count_ff - CB'(dist_in);
         end

         // Move entries above the split point up by one.
         cra_pkg::S_SHIFT_UP: begin
            mem_raddr = IB'(scan_ff - CB'(1));
            if (up_more) begin
               pend_in = 1'b1;
               pidx_in = scan_ff;
               scan_in = scan_ff - CB'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_waddr = pidx_ff[IB-1:0];
               mem_wdata = rdata;
            end
         end

         // Mark the chosen region used.
         cra_pkg::S_SPLIT_LO: begin
            mem_we = 1'b1;
            mem_waddr = hit_ff;
            mem_wdata.start_addr = hit_ent_ff.start_addr;
            mem_wdata.end_addr = 16'({1'b0, hit_ent_ff.start_addr} + size_ff - 17'd1);
            mem_wdata.owner = owner_ff;
            mem_wdata.used = 1'b1;
            res_in.status = cra_pkg::ST_OK;
            res_in.region_index = hit_ff;
            res_in.region_start = mem_wdata.start_addr;
            res_in.region_end = mem_wdata.end_addr;
            res_in.region_owner = owner_ff;
            res_in.region_used = 1'b1;
            res_in.region_total = count_ff + CB'(alloc_split);
         end

         // Write the free remainder just above the chosen region.
         cra_pkg::S_SPLIT_HI: begin
            mem_we = 1'b1;
            mem_waddr = hit_ff + IB'(1);
            mem_wdata.start_addr = 16'({1'b0, hit_ent_ff.start_addr} + size_ff);
            mem_wdata.end_addr = hit_ent_ff.end_addr;
            count_in = count_ff + CB'(1);
         end

         // Close the gap left by merged entries.
         cra_pkg::S_SHIFT_DN: begin
            mem_raddr = IB'(scan_ff + CB'(dist_ff));
            if (dn_more) begin
               pend_in = 1'b1;
               pidx_in = scan_ff;
               scan_in = scan_ff + CB'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_waddr = pidx_ff[IB-1:0];
               mem_wdata = rdata;
            end
            if (!dn_more && !pend_ff) begin
               count_in = count_ff - CB'(dist_ff);
            end
         end

         // Return one table entry.
         cra_pkg::S_READ_WAIT: begin
            if (pidx_ff < count_ff) begin
               res_in.status = cra_pkg::ST_OK;
               res_in.region_index = pidx_ff[IB-1:0];
               res_in.region_start = rdata.start_addr;
               res_in.region_end = rdata.end_addr;
               res_in.region_owner = rdata.owner;
               res_in.region_used = rdata.used;
            end else begin
               res_in.status = cra_pkg::ST_BAD;
            end
         end

         default: begin
         end
      endcase

      if (csr_we) begin
         pool_in = pool_clamp;
      end
   end

   // Output register: loaded from the result, cleared when the beat is taken.
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == cra_pkg::S_RESP && out_free) begin
         rsp_in = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cra_pkg::S_INIT;
         pool_ff <= cra_pkg::POOL_MAX;
         count_ff <= CB'(1);
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      owner_ff <= owner_in;
      size_ff <= size_in;
      policy_ff <= policy_in;
      scan_ff <= scan_in;
      pidx_ff <= pidx_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      hit_ent_ff <= hit_ent_in;
      hit_len_ff <= hit_len_in;
      prev_ent_ff <= prev_ent_in;
      prev_free_ff <= prev_free_in;
      ptr_ff <= ptr_in;
      kept_ff <= kept_in;
      dist_ff <= dist_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_ff;

   // The entry count never exceeds the table depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_CNT)
      else $error("entry count above table depth");

   // A result appears only after the sequencer has finished an operation.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cra_pkg::S_RESP))
      else $error("result raised outside the response state");

   // No table read is still in flight when a new request can be taken.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == cra_pkg::S_IDLE |-> !pend_ff)
      else $error("pending table read while idle");

endmodule
